// ===== design/ppm_sum_frame_decoder_macros.svh =====
// Assertion macros for the PPM-sum frame decoder.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef PPM_SUM_FRAME_DECODER_MACROS_SVH
`define PPM_SUM_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every edge outside reset
`define PSFD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent
`define PSFD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after its antecedent
`define PSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PSFD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define PSFD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/psfd_pkg.sv =====
package psfd_pkg;

   // Channel slots per frame
   localparam int MAX_CHANNELS = 10;
   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   // Request kinds
   localparam logic [1:0] KIND_CAPTURE   = 2'd0;
   localparam logic [1:0] KIND_CAL_START = 2'd1;
   localparam logic [1:0] KIND_CAL_STOP  = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_FRAME  = 2'd0;
   localparam logic [1:0] STATUS_SHORT  = 2'd1;
   localparam logic [1:0] STATUS_REPORT = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_COUNTER_TOP     = 2'd0;
   localparam logic [1:0] CSR_SYNC_THRESHOLD  = 2'd1;
   localparam logic [1:0] CSR_CHANNELS_IN_USE = 2'd2;
   localparam logic [1:0] CSR_FEWEST_CHANNELS = 2'd3;

   // Register reset values
   localparam logic [15:0] COUNTER_TOP_RESET     = 16'd39999;
   localparam logic [15:0] SYNC_THRESHOLD_RESET  = 16'd5400;
   localparam logic [3:0]  CHANNELS_IN_USE_RESET = 4'd10;
   localparam logic [3:0]  FEWEST_CHANNELS_RESET = 4'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] capture_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  channel;
      logic [14:0] width_us;
      logic [14:0] center_us;
      logic [14:0] min_us;
      logic [14:0] max_us;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] counter_top;
      logic [15:0] sync_threshold;
      logic [3:0]  channels_in_use;
      logic [3:0]  fewest_channels;
   } cfg_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_WIDTH,
      SEQ_JUDGE,
      SEQ_SHORT,
      SEQ_FRAME,
      SEQ_SEED,
      SEQ_REPORT
   } seq_state_type;

   typedef enum logic [1:0] {
      CH_NONE,
      CH_FRAME,
      CH_SEED,
      CH_REPORT
   } chan_op_type;

   // Sequencer to channel store
   typedef struct packed {
      chan_op_type      op;
      logic [IDX_W-1:0] idx;
      logic             calibrating;
      logic             store_we;
      logic [15:0]      store_data;
   } chan_ctrl_type;

   // Channel store read-out, after any update of this step
   typedef struct packed {
      logic [14:0] width;
      logic [14:0] center;
      logic [14:0] lo;
      logic [14:0] hi;
   } chan_read_type;

   // Sequencer to response register
   typedef struct packed {
      logic             load;
      logic [1:0]       status;
      logic [IDX_W-1:0] idx;
      logic             last;
   } emit_type;

endpackage

// ===== design/ppm_sum_frame_decoder.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_type: kind, capture_time
// rsp      out        rsp_valid/rsp_stall   rsp_type: status .. last
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// A capture edge inside a frame steps through accept, width and judge.
// A sync edge then adds one frame step per stored channel (short frame: one
// short step); calibration start and stop add one step per channel in use.
// The per-channel steps are set by the single shared min/max compare unit.
// Reset is synchronous; no clearing pass.
// A stalled response holds the sequencer in its emit step.
`include "ppm_sum_frame_decoder_macros.svh"

module ppm_sum_frame_decoder
   import psfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type       cfg_ff, cfg_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   chan_ctrl_type chan_ctrl;
   chan_read_type chan_rd;
   emit_type      emit;
   logic          is_short;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   psfd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_free  (out_free),
      .chan_ctrl (chan_ctrl),
      .emit      (emit)
   );

   psfd_chan_store u_chan_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (chan_ctrl),
      .rd    (chan_rd)
   );

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COUNTER_TOP:     cfg_in.counter_top     = csr_data;
            CSR_SYNC_THRESHOLD:  cfg_in.sync_threshold  = csr_data;
            CSR_CHANNELS_IN_USE: cfg_in.channels_in_use = csr_data[3:0];
            CSR_FEWEST_CHANNELS: cfg_in.fewest_channels = csr_data[3:0];
         endcase
      end
   end

   // Assemble the response; a short frame carries zeros
   always_comb begin
      is_short         = (emit.status == STATUS_SHORT);
      rsp_in.status    = emit.status;
      rsp_in.channel   = is_short ? 4'd0 : 4'(emit.idx);
      rsp_in.width_us  = is_short ? 15'd0 : chan_rd.width;
      rsp_in.center_us = is_short ? 15'd0 : chan_rd.center;
      rsp_in.min_us    = is_short ? 15'd0 : chan_rd.lo;
      rsp_in.max_us    = is_short ? 15'd0 : chan_rd.hi;
      rsp_in.last      = emit.last;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{counter_top:     COUNTER_TOP_RESET,
                           sync_threshold:  SYNC_THRESHOLD_RESET,
                           channels_in_use: CHANNELS_IN_USE_RESET,
                           fewest_channels: FEWEST_CHANNELS_RESET};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload: load on emit, hold otherwise
   always_ff @(posedge clock) begin
      if (emit.load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Never overwrite a response that is still stalled
   `PSFD_ASSERT_ALWAYS(a_no_overwrite, clock, reset, !(emit.load && rsp_valid_ff && rsp_stall), "response overwritten while stalled")

   // A capture transaction keeps the block busy for the width step
   `PSFD_ASSERT_NEXT(a_capture_busy, clock, reset, req_valid && !req_stall && (req_data.kind == KIND_CAPTURE), req_stall, "capture accepted without width step")

   // A short frame is a single zero-channel result
   `PSFD_ASSERT_IMPL(a_short_single, clock, reset, rsp_valid && (rsp_data.status == STATUS_SHORT), rsp_data.last && (rsp_data.channel == 4'd0), "malformed short frame result")

endmodule

// ===== design/psfd_chan_store.sv =====
module psfd_chan_store
   import psfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chan_ctrl_type ctrl,
   output chan_read_type rd
);

   logic [15:0] pulse_ff  [MAX_CHANNELS];
   logic [14:0] last_ff   [MAX_CHANNELS];
   logic [14:0] center_ff [MAX_CHANNELS];
   logic [14:0] lo_ff     [MAX_CHANNELS];
   logic [14:0] hi_ff     [MAX_CHANNELS];

   logic [14:0] last_in;
   logic [14:0] center_in;
   logic [14:0] lo_in;
   logic [14:0] hi_in;
   logic        last_we;
   logic        center_we;
   logic        bound_we;

   logic [14:0] w;
   logic [14:0] cur_last;
   logic [14:0] cur_center;
   logic [14:0] cur_lo;
   logic [14:0] cur_hi;
   logic [14:0] lo_sel;
   logic [14:0] hi_sel;

   // Read the addressed channel and run the shared min/max compare
   always_comb begin
      w          = pulse_ff[ctrl.idx][15:1];
      cur_last   = last_ff[ctrl.idx];
      cur_center = center_ff[ctrl.idx];
      cur_lo     = lo_ff[ctrl.idx];
      cur_hi     = hi_ff[ctrl.idx];
      lo_sel     = (ctrl.calibrating && (w < cur_lo)) ? w : cur_lo;
      hi_sel     = (ctrl.calibrating && (w > cur_hi)) ? w : cur_hi;
   end

   // Select update and read-out for the current step
   always_comb begin
      last_we   = 1'b0;
      center_we = 1'b0;
      bound_we  = 1'b0;
      last_in   = w;
      center_in = cur_last;
      lo_in     = lo_sel;
      hi_in     = hi_sel;
      rd        = '{width: cur_last, center: cur_center, lo: cur_lo, hi: cur_hi};
      unique case (ctrl.op)
         CH_FRAME: begin
            last_we  = 1'b1;
            bound_we = 1'b1;
            rd       = '{width: w, center: cur_center, lo: lo_sel, hi: hi_sel};
         end
         CH_SEED: begin
            center_we = 1'b1;
            bound_we  = 1'b1;
            lo_in     = cur_last;
            hi_in     = cur_last;
         end
         CH_REPORT, CH_NONE: begin
         end
      endcase
   end

   // Pulse store: written before read, no reset
   always_ff @(posedge clock) begin
      if (ctrl.store_we) begin
         pulse_ff[ctrl.idx] <= ctrl.store_data;
      end
   end

   // Calibration tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            last_ff[i]   <= '0;
            center_ff[i] <= '0;
            lo_ff[i]     <= '0;
            hi_ff[i]     <= '0;
         end
      end else begin
         if (last_we) begin
            last_ff[ctrl.idx] <= last_in;
         end
         if (center_we) begin
            center_ff[ctrl.idx] <= center_in;
         end
         if (bound_we) begin
            lo_ff[ctrl.idx] <= lo_in;
            hi_ff[ctrl.idx] <= hi_in;
         end
      end
   end

endmodule

// ===== design/psfd_seq.sv =====
module psfd_seq
   import psfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_valid,
   input  req_type       req_data,
   output logic          req_stall,
   input  logic          out_free,
   output chan_ctrl_type chan_ctrl,
   output emit_type      emit
);

   seq_state_type    state_ff, state_in;
   logic [15:0]      prev_ff, prev_in;
   logic [15:0]      stamp_ff, stamp_in;
   logic [15:0]      width_ff, width_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic [IDX_W-1:0] iter_ff, iter_in;
   logic             cal_ff, cal_in;

   logic             accept;
   logic [4:0]       use_ext;
   logic [4:0]       used;
   logic [CNT_W-1:0] n;
   logic             is_last;
   logic             sync;
   logic             short_frame;
   logic             store_ok;
   logic [16:0]      wrap_sum;
   logic [15:0]      width_calc;

   assign req_stall = (state_ff != SEQ_IDLE);
   assign accept    = req_valid && !req_stall;

   // Clamp channels in use to the slot count
   always_comb begin
      use_ext = {1'b0, cfg.channels_in_use};
      used    = (use_ext > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : use_ext;
      n       = CNT_W'(used);
   end

   // Loop end, sync and frame length checks
   always_comb begin
      is_last     = ((CNT_W'(iter_ff) + CNT_W'(1)) == end_ff);
      sync        = (width_ff > cfg.sync_threshold);
      short_frame = (5'(count_ff) < {1'b0, cfg.fewest_channels});
      store_ok    = (count_ff < n);
   end

   // Pulse width with timer wrap
   always_comb begin
      wrap_sum = {1'b0, cfg.counter_top} + 17'd1 + {1'b0, stamp_ff} - {1'b0, prev_ff};
      if (stamp_ff < prev_ff) begin
         width_calc = wrap_sum[15:0];
      end else begin
         width_calc = stamp_ff - prev_ff;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_CAPTURE: state_in = SEQ_WIDTH;
                  KIND_CAL_START: begin
                     if (n != CNT_W'(0)) state_in = SEQ_SEED;
                  end
                  KIND_CAL_STOP: begin
                     if (cal_ff && (n != CNT_W'(0))) state_in = SEQ_REPORT;
                  end
                  default: state_in = SEQ_IDLE;
               endcase
            end
         end
         SEQ_WIDTH: state_in = SEQ_JUDGE;
         SEQ_JUDGE: begin
            priority if (!sync)                  state_in = SEQ_IDLE;
            else if (short_frame)                state_in = SEQ_SHORT;
            else if (count_ff != CNT_W'(0))      state_in = SEQ_FRAME;
            else                                 state_in = SEQ_IDLE;
         end
         SEQ_SHORT: begin
            if (out_free) state_in = SEQ_IDLE;
         end
         SEQ_FRAME, SEQ_REPORT: begin
            if (out_free && is_last) state_in = SEQ_IDLE;
         end
         SEQ_SEED: begin
            if (is_last) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Control outputs to the channel store and response register
   always_comb begin
      chan_ctrl = '{op: CH_NONE, idx: iter_ff, calibrating: cal_ff,
                    store_we: 1'b0, store_data: width_ff};
      emit      = '{load: 1'b0, status: STATUS_FRAME, idx: iter_ff, last: is_last};
      unique case (state_ff)
         SEQ_JUDGE: begin
            chan_ctrl.idx      = IDX_W'(count_ff);
            chan_ctrl.store_we = !sync && store_ok;
         end
         SEQ_SHORT: begin
            emit.load   = out_free;
            emit.status = STATUS_SHORT;
            emit.idx    = '0;
            emit.last   = 1'b1;
         end
         SEQ_FRAME: begin
            chan_ctrl.op = out_free ? CH_FRAME : CH_NONE;
            emit.load    = out_free;
         end
         SEQ_SEED: begin
            chan_ctrl.op = CH_SEED;
         end
         SEQ_REPORT: begin
            chan_ctrl.op = out_free ? CH_REPORT : CH_NONE;
            emit.load    = out_free;
            emit.status  = STATUS_REPORT;
         end
         default: begin
         end
      endcase
   end

   // Datapath register updates
   always_comb begin
      prev_in  = prev_ff;
      stamp_in = stamp_ff;
      width_in = width_ff;
      count_in = count_ff;
      end_in   = end_ff;
      iter_in  = iter_ff;
      cal_in   = cal_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               stamp_in = req_data.capture_time;
               iter_in  = '0;
               end_in   = n;
               if (req_data.kind == KIND_CAL_START) cal_in = 1'b1;
               if (req_data.kind == KIND_CAL_STOP)  cal_in = 1'b0;
            end
         end
         SEQ_WIDTH: begin
            width_in = width_calc;
            prev_in  = stamp_ff;
         end
         SEQ_JUDGE: begin
            if (sync) begin
               count_in = '0;
               end_in   = count_ff;
               iter_in  = '0;
            end else if (store_ok) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         SEQ_FRAME, SEQ_REPORT: begin
            if (out_free && !is_last) iter_in = iter_ff + IDX_W'(1);
         end
         SEQ_SEED: begin
            if (!is_last) iter_in = iter_ff + IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         prev_ff  <= '0;
         count_ff <= '0;
         cal_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
         cal_ff   <= cal_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      width_ff <= width_in;
      end_ff   <= end_in;
      iter_ff  <= iter_in;
   end

endmodule

// ===== dv/ppm_sum_frame_decoder_tb.sv =====
module ppm_sum_frame_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psfd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int GAP_CAP      = 20;
   // The one kind code the block does not act on
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // Traffic shaping
   int   idle_pct = 0;
   int   stall_pct = 0;
   logic hold_on = 1'b0;
   event hold_go;
   int   timer_pos = 0;
   int   cycle_count = 0;
   int   fault_count = 0;

   // Decoder copy: registers
   logic [15:0] top_cfg = COUNTER_TOP_RESET;
   logic [15:0] sync_cfg = SYNC_THRESHOLD_RESET;
   logic [3:0]  chans_cfg = CHANNELS_IN_USE_RESET;
   logic [3:0]  fewest_cfg = FEWEST_CHANNELS_RESET;

   // Decoder copy: state
   logic [15:0] prev_stamp = '0;
   int          stored_count = 0;
   logic [15:0] pulse_mem [MAX_CHANNELS];
   logic [14:0] last_w [MAX_CHANNELS] = '{default: '0};
   logic [14:0] center_w [MAX_CHANNELS] = '{default: '0};
   logic [14:0] min_w [MAX_CHANNELS] = '{default: '0};
   logic [14:0] max_w [MAX_CHANNELS] = '{default: '0};
   logic        cal_on = 1'b0;

   rsp_type due_rsps [$];

   ppm_sum_frame_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_fault(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fault_count++;
   endtask

   function automatic void queue_rsp(logic [1:0] st, int ch, logic [14:0] w, logic [14:0] c,
                                     logic [14:0] lo, logic [14:0] hi, logic lst);
      rsp_type r;
      r.status    = st;
      r.channel   = 4'(ch);
      r.width_us  = w;
      r.center_us = c;
      r.min_us    = lo;
      r.max_us    = hi;
      r.last      = lst;
      due_rsps.push_back(r);
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [15:0] value);
      case (idx)
         CSR_COUNTER_TOP:     top_cfg = value;
         CSR_SYNC_THRESHOLD:  sync_cfg = value;
         CSR_CHANNELS_IN_USE: chans_cfg = value[3:0];
         CSR_FEWEST_CHANNELS: fewest_cfg = value[3:0];
         default: ;
      endcase
   endfunction

   // Work out the results one accepted transaction causes
   function automatic void decode_transaction(req_type r);
      logic [31:0] span;
      logic [15:0] width;
      logic [14:0] w;
      int          n;
      int          cnt;
      n = (chans_cfg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chans_cfg);
      case (r.kind)
         KIND_CAPTURE: begin
            if (r.capture_time < prev_stamp)
               span = 32'(top_cfg) + 32'd1 + 32'(r.capture_time) - 32'(prev_stamp);
            else
               span = 32'(r.capture_time) - 32'(prev_stamp);
            width = span[15:0];
            prev_stamp = r.capture_time;
            if (width > sync_cfg) begin
               cnt = stored_count;
               if (cnt < fewest_cfg) begin
                  queue_rsp(STATUS_SHORT, 0, '0, '0, '0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < cnt; i++) begin
                     w = pulse_mem[i][15:1];
                     last_w[i] = w;
                     if (cal_on) begin
                        if (w < min_w[i]) min_w[i] = w;
                        if (w > max_w[i]) max_w[i] = w;
                     end
                     queue_rsp(STATUS_FRAME, i, w, center_w[i], min_w[i], max_w[i],
                               i + 1 == cnt);
                  end
               end
               stored_count = 0;
            end else if (stored_count < n) begin
               pulse_mem[stored_count] = width;
               stored_count++;
            end
         end
         KIND_CAL_START: begin
            cal_on = 1'b1;
            for (int i = 0; i < n; i++) begin
               center_w[i] = last_w[i];
               min_w[i]    = last_w[i];
               max_w[i]    = last_w[i];
            end
         end
         KIND_CAL_STOP: begin
            if (cal_on) begin
               for (int i = 0; i < n; i++)
                  queue_rsp(STATUS_REPORT, i, last_w[i], center_w[i], min_w[i], max_w[i],
                            i + 1 == n);
               cal_on = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic compare_field(string name, logic [14:0] got, logic [14:0] want);
      if (got !== want)
         report_fault($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic check_rsp(rsp_type got);
      rsp_type want;
      if (due_rsps.size() == 0) begin
         report_fault($sformatf("unexpected result status %0d channel %0d",
                                got.status, got.channel));
         return;
      end
      want = due_rsps.pop_front();
      compare_field("status", 15'(got.status), 15'(want.status));
      compare_field("channel", 15'(got.channel), 15'(want.channel));
      compare_field("width_us", got.width_us, want.width_us);
      compare_field("center_us", got.center_us, want.center_us);
      compare_field("min_us", got.min_us, want.min_us);
      compare_field("max_us", got.max_us, want.max_us);
      compare_field("last", 15'(got.last), 15'(want.last));
   endtask

   // Check each result transaction, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         check_rsp(rsp_data);
      rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
   end

   // Long receiver hold-off
   initial begin
      forever begin
         @(hold_go);
         hold_on <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   // Offer one transaction; valid stays high for a back-to-back successor
   task automatic send_req(logic [1:0] kind, logic [15:0] stamp);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < GAP_CAP) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, capture_time: stamp};
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      if (kind == KIND_CAPTURE) timer_pos = stamp;
      decode_transaction('{kind: kind, capture_time: stamp});
   endtask

   // Capture edge a given number of ticks after the last one
   task automatic send_capture_after(int ticks);
      int top1;
      top1 = int'(top_cfg) + 1;
      send_req(KIND_CAPTURE, 16'(((timer_pos % top1) + ticks) % top1));
   endtask

   // Drop valid and wait until the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (due_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_csr(idx, value);
   endtask

   task automatic setup_registers(int top_v, int sync_v, int chans_v, int fewest_v);
      settle();
      write_csr(CSR_COUNTER_TOP, 16'(top_v));
      write_csr(CSR_SYNC_THRESHOLD, 16'(sync_v));
      write_csr(CSR_CHANNELS_IN_USE, {12'($urandom), 4'(chans_v)});
      write_csr(CSR_FEWEST_CHANNELS, {12'($urandom), 4'(fewest_v)});
      csr_valid <= 1'b0;
   endtask

   // Frames, short frames and calibration at reset register values
   task automatic test_reset_frames();
      idle_pct  = 0;
      stall_pct = 0;
      send_capture_after(6000);
      for (int i = 0; i < 6; i++) send_capture_after(1800 + 350 * i);
      send_capture_after(9000);
      send_capture_after(2100);
      send_capture_after(2200);
      send_capture_after(7000);
      send_req(KIND_CAL_START, 16'h0000);
      // one pulse beyond the channels in use is dropped
      for (int i = 0; i < 11; i++) send_capture_after(4500 - 300 * i);
      send_capture_after(12000);
      send_req(KIND_CAL_STOP, 16'hFFFF);
      send_req(KIND_CAL_STOP, 16'h5A5A);
      send_req(KIND_SPARE, 16'hFFFF);
      send_req(KIND_SPARE, 16'h0000);
      // stamp extremes, the second one wrapping
      send_req(KIND_CAPTURE, 16'hFFFF);
      send_req(KIND_CAPTURE, 16'h0000);
   endtask

   // Register extremes, empty frames and channel count lowered mid-frame
   task automatic test_register_extremes();
      setup_registers(65535, 0, 15, 0);
      send_capture_after(0);
      send_capture_after(0);
      send_capture_after(5);
      send_capture_after(5);
      setup_registers(65535, 0, 0, 0);
      send_req(KIND_CAL_START, 16'h1234);
      send_req(KIND_CAL_STOP, 16'hEDCB);
      send_req(KIND_CAL_STOP, 16'h0F0F);
      setup_registers(0, 65535, 10, 15);
      send_req(KIND_CAPTURE, 16'h0010);
      send_req(KIND_CAPTURE, 16'h0008);
      send_req(KIND_CAPTURE, 16'h0009);
      send_req(KIND_CAPTURE, 16'hFFFF);
      setup_registers(0, 100, 2, 0);
      send_req(KIND_CAPTURE, 16'h1000);
   endtask

   // Mostly well-formed frames with calibration, plus noise
   task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
      int sent;
      int pick;
      int k;
      int w;
      int top_v;
      int sync_v;
      settle();
      idle_pct  = send_pct;
      stall_pct = recv_pct;
      pick  = $urandom_range(2);
      top_v = (pick == 0) ? 39999 : (pick == 1) ? 65535 : $urandom_range(65535, 12000);
      sync_v = $urandom_range(top_v / 3, 1500);
      setup_registers(top_v, sync_v, $urandom_range(15), $urandom_range(11));
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_capture_after($urandom_range(top_v, sync_v + 1));
            sent++;
            k = $urandom_range(12);
            repeat (k) begin
               w = $urandom_range(4200, 1800);
               if (w > sync_v) w = $urandom_range(sync_v);
               send_capture_after(w);
               sent++;
            end
         end else if (pick < 78) begin
            send_req(KIND_CAL_START, 16'($urandom));
            sent++;
         end else if (pick < 86) begin
            send_req(KIND_CAL_STOP, 16'($urandom));
            sent++;
         end else if (pick < 95) begin
            send_req(KIND_CAPTURE, 16'($urandom));
            sent++;
         end else begin
            send_req(KIND_SPARE, 16'($urandom));
         end
      end
   endtask

   // Receiver holds off while full frames keep arriving
   task automatic test_backpressure();
      settle();
      idle_pct  = 0;
      stall_pct = 0;
      setup_registers(39999, 5400, 10, 0);
      -> hold_go;
      repeat (4) begin
         send_capture_after(8000);
         for (int i = 0; i < 10; i++) send_capture_after($urandom_range(4000, 2000));
      end
      send_capture_after(8000);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_frames();
      test_register_extremes();
      test_random_traffic(0, 0, 45);
      test_random_traffic(69, 0, 45);
      test_random_traffic(0, 69, 45);
      test_random_traffic(33, 33, 45);
      test_backpressure();
      settle();
      if (fault_count == 0 && due_rsps.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== ppm_sum_frame_decoder.f =====
+incdir+design
design/psfd_pkg.sv
design/psfd_chan_store.sv
design/psfd_seq.sv
design/ppm_sum_frame_decoder.sv
dv/ppm_sum_frame_decoder_tb.sv
